[hdl/bdq_pkg.sv]
// ----------------------------------------------------------------------------
// bdq_pkg
// Types and constants shared by the bounded double-ended queue.
// ----------------------------------------------------------------------------
`default_nettype none

package bdq_pkg;

   localparam int WORD_W        = 32;
   localparam int KIND_W        = 3;
   localparam int STATUS_W      = 2;
   localparam int COUNT_W       = 5;
   localparam int DEPTH_DEFAULT = 16;

   localparam logic [COUNT_W-1:0] CAPACITY_RESET = COUNT_W'(16);

   localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd0;
   localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 3'd1;
   localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd2;
   localparam logic [KIND_W-1:0] KIND_POP_BACK   = 3'd3;
   localparam logic [KIND_W-1:0] KIND_NOP        = 3'd4;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

   typedef struct packed {
      logic [KIND_W-1:0]        kind;
      logic signed [WORD_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] popped_value;
      logic [STATUS_W-1:0]      status;
      logic [COUNT_W-1:0]       occupancy_now;
      logic signed [WORD_W-1:0] front_value;
      logic signed [WORD_W-1:0] back_value;
   } rsp_type;

   // one-hot (or all-zero for no operation) control broadcast to every cell
   typedef struct packed {
      logic push_front;
      logic push_back;
      logic pop_front;
      logic pop_back;
   } cell_ctrl_type;

endpackage : bdq_pkg

`default_nettype wire

[hdl/bdq_cell.sv]
// ----------------------------------------------------------------------------
// bdq_cell
// One slot of the queue row: a word and its occupied flag. Shifts toward the
// back on push front, toward the front on pop front, fills as the first free
// slot on push back and frees itself as the last used slot on pop back.
// ----------------------------------------------------------------------------
`default_nettype none

module bdq_cell
   import bdq_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire cell_ctrl_type            ctrl,
   input  wire logic signed [WORD_W-1:0] push_value,
   input  wire logic signed [WORD_W-1:0] left_data,
   input  wire logic                     left_valid,
   input  wire logic signed [WORD_W-1:0] right_data,
   input  wire logic                     right_valid,
   output logic signed [WORD_W-1:0]      data,
   output logic                          valid,
   output logic                          is_back
);

   logic signed [WORD_W-1:0] data_ff, data_in;
   logic                     valid_ff, valid_in;

   always_comb begin
      data_in  = data_ff;
      valid_in = valid_ff;
      if (ctrl.push_front) begin
         data_in  = left_data;
         valid_in = left_valid;
      end else if (ctrl.pop_front) begin
         data_in  = right_data;
         valid_in = right_valid;
      end else if (ctrl.push_back) begin
         if (!valid_ff && left_valid) begin
            data_in  = push_value;
            valid_in = 1'b1;
         end
      end else if (ctrl.pop_back) begin
         if (valid_ff && !right_valid) begin
            valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign data    = data_ff;
   assign valid   = valid_ff;
   assign is_back = valid_ff && !right_valid;

endmodule : bdq_cell

`default_nettype wire

[hdl/bounded_double_ended_queue.sv]
// ----------------------------------------------------------------------------
// bounded_double_ended_queue
// Bounded deque of signed words held in a row of shifting cells;
// cell 0 is the front. One response per request.
// ----------------------------------------------------------------------------
//   channel   handshake             payload
//   req       req_valid/req_stall   req_data  (req_type)
//   rsp       rsp_valid/rsp_stall   rsp_data  (rsp_type)
//   csr       csr_valid/csr_ready   csr_data  (capacity)
//
// A request is applied to the cell row in the cycle it is accepted; its
// response is valid on the next cycle. req_stall stays high while a response
// is held, so a new request is accepted only after the last response is taken.
// Synchronous reset empties the row and sets capacity to 16.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_double_ended_queue
   import bdq_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
)
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire req_type            req_data,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output rsp_type                 rsp_data,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [COUNT_W-1:0] csr_data
);

   localparam int OCC_W = $clog2(DEPTH + 1);
   localparam int CMP_W = (OCC_W > COUNT_W) ? OCC_W : COUNT_W;

   logic [COUNT_W-1:0]       capacity_ff, capacity_in;
   logic [OCC_W-1:0]         occ_ff, occ_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [WORD_W-1:0] popped_ff, popped_in;
   logic [STATUS_W-1:0]      status_ff, status_in;

   logic                     accept;
   logic                     full;
   logic                     empty;
   logic [CMP_W-1:0]         usable_cap;
   cell_ctrl_type            ctrl;
   logic signed [WORD_W-1:0] back_word;

   logic signed [WORD_W-1:0] cell_data  [DEPTH];
   logic                     cell_valid [DEPTH];
   logic                     cell_back  [DEPTH];

   assign accept    = req_valid && !req_stall;
   assign req_stall = rsp_valid_ff;
   assign csr_ready = 1'b1;

   assign usable_cap = (CMP_W'(capacity_ff) > CMP_W'(DEPTH)) ? CMP_W'(DEPTH)
                                                             : CMP_W'(capacity_ff);
   assign full  = CMP_W'(occ_ff) >= usable_cap;
   assign empty = (occ_ff == '0);

   always_comb begin
      back_word = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (cell_back[i]) begin
            back_word = back_word | cell_data[i];
         end
      end
   end

   always_comb begin
      ctrl         = '0;
      status_in    = status_ff;
      popped_in    = popped_ff;
      occ_in       = occ_ff;
      capacity_in  = capacity_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (csr_valid && csr_ready) begin
         capacity_in = csr_data;
      end
      if (accept) begin
         rsp_valid_in = 1'b1;
         status_in    = STATUS_OK;
         popped_in    = '0;
         case (req_data.kind)
            KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
               if (full) begin
                  status_in = STATUS_FULL;
               end else begin
                  ctrl.push_front = (req_data.kind == KIND_PUSH_FRONT);
                  ctrl.push_back  = (req_data.kind == KIND_PUSH_BACK);
                  occ_in          = occ_ff + OCC_W'(1);
               end
            end
            KIND_POP_FRONT: begin
               if (empty) begin
                  status_in = STATUS_EMPTY;
               end else begin
                  ctrl.pop_front = 1'b1;
                  popped_in      = cell_data[0];
                  occ_in         = occ_ff - OCC_W'(1);
               end
            end
            KIND_POP_BACK: begin
               if (empty) begin
                  status_in = STATUS_EMPTY;
               end else begin
                  ctrl.pop_back = 1'b1;
                  popped_in     = back_word;
                  occ_in        = occ_ff - OCC_W'(1);
               end
            end
            KIND_NOP: begin
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      popped_ff <= popped_in;
      status_ff <= status_in;
      if (reset) begin
         capacity_ff  <= CAPACITY_RESET;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         capacity_ff  <= capacity_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic signed [WORD_W-1:0] left_data, right_data;
      logic                     left_valid, right_valid;

      if (i == 0) begin : g_first
         assign left_data  = req_data.value;
         assign left_valid = 1'b1;
      end else begin : g_inner_left
         assign left_data  = cell_data[i-1];
         assign left_valid = cell_valid[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_data  = '0;
         assign right_valid = 1'b0;
      end else begin : g_inner_right
         assign right_data  = cell_data[i+1];
         assign right_valid = cell_valid[i+1];
      end

      bdq_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .push_value  (req_data.value),
         .left_data   (left_data),
         .left_valid  (left_valid),
         .right_data  (right_data),
         .right_valid (right_valid),
         .data        (cell_data[i]),
         .valid       (cell_valid[i]),
         .is_back     (cell_back[i])
      );
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_data.popped_value  = popped_ff;
   assign rsp_data.status        = status_ff;
   assign rsp_data.occupancy_now = COUNT_W'(occ_ff);
   assign rsp_data.front_value   = cell_valid[0] ? cell_data[0] : '0;
   assign rsp_data.back_value    = back_word;

endmodule : bounded_double_ended_queue

`default_nettype wire
